/* sv/pdr_pkg.sv */
package pdr_pkg;

  localparam int unsigned COORD_W = 16;
  localparam int unsigned KEY_W   = 2 * COORD_W;
  localparam int unsigned DIST_W  = 9;
  localparam int unsigned REP_W   = 16;

  localparam logic [REP_W-1:0] REP_MAX = '1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;   // latch the accepted item and restart the scan
    logic issue;   // read the next stored entry
    logic commit;  // update the table and counts, load the result register
  } pdr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic match;     // the entry read last cycle equals the current point
    logic scan_end;  // every stored entry has been read; the last one is compared now
    logic out_free;  // the result register can take a new item
  } pdr_stat_t;

endpackage

/* sv/pdr_if.sv */
interface pdr_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [pdr_pkg::COORD_W-1:0]  px;
  logic signed [pdr_pkg::COORD_W-1:0]  py;
  logic                                final_point;

  modport source (output valid, output px, output py, output final_point, input ready);
  modport sink   (input valid, input px, input py, input final_point, output ready);
endinterface

interface pdr_out_if;
  logic                                valid;
  logic                                ready;
  logic                                kept;
  logic signed [pdr_pkg::COORD_W-1:0]  out_x;
  logic signed [pdr_pkg::COORD_W-1:0]  out_y;
  logic        [pdr_pkg::DIST_W-1:0]   distinct_count;
  logic        [pdr_pkg::REP_W-1:0]    repeat_count;
  logic                                table_overflow;
  logic                                figure_end;

  modport source (output valid, output kept, output out_x, output out_y,
                  output distinct_count, output repeat_count,
                  output table_overflow, output figure_end, input ready);
  modport sink   (input valid, input kept, input out_x, input out_y,
                  input distinct_count, input repeat_count,
                  input table_overflow, input figure_end, output ready);
endinterface

/* sv/point_duplicate_removal.sv */
// Point duplicate removal for one drawn figure.
//
// The in_ch channel takes one point per item: signed px and py and the
// final_point flag. The out_ch channel gives exactly one result per point:
// whether it was kept, the echoed coordinates, the distinct and repeat
// totals for the figure so far, a table overflow flag and the figure end
// echo. Both channels move an item when valid and ready are high together.
//
// Each point is compared with the stored distinct points of the figure, one
// entry per cycle from a table memory with one write port and a registered
// read port. The scan reads entries until a match or until all stored
// entries (at most MAX_POINTS) have been read, and then the result is
// loaded into the output register; the next point is accepted the cycle
// after the result is loaded, so a new point waits until the last is done.
//
// The result sits in an output register. If the receiver stalls, the block
// holds its finished result and waits before loading the next one.
// Synchronous reset clears the counts and control state; the table needs
// no clearing since only entries below the stored count are ever read.
module point_duplicate_removal #(
  parameter int unsigned MAX_POINTS = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  pdr_in_if.sink    in_ch,
  pdr_out_if.source out_ch
);

  pdr_pkg::pdr_cmd_t  cmd;
  pdr_pkg::pdr_stat_t stat;

  // The controller sequences accept, scan and result; it never sees payload.
  pdr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds the table memory, the counters and the result register.
  pdr_datapath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .px          (in_ch.px),
    .py          (in_ch.py),
    .final_point (in_ch.final_point),
    .cmd         (cmd),
    .stat        (stat),
    .out_ch      (out_ch)
  );

endmodule

/* sv/pdr_datapath.sv */
module pdr_datapath #(
  parameter int unsigned MAX_POINTS = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic signed [pdr_pkg::COORD_W-1:0]  px,
  input  logic signed [pdr_pkg::COORD_W-1:0]  py,
  input  logic                                final_point,
  input  pdr_pkg::pdr_cmd_t                   cmd,
  output pdr_pkg::pdr_stat_t                  stat,
  pdr_out_if.source                           out_ch
);

  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(MAX_POINTS);

  logic [pdr_pkg::KEY_W-1:0]   mem [MAX_POINTS];

  logic signed [pdr_pkg::COORD_W-1:0] key_x_r;
  logic signed [pdr_pkg::COORD_W-1:0] key_y_r;
  logic                               fin_r;
  logic [pdr_pkg::KEY_W-1:0]          rd_data_r;
  logic [CW-1:0]                      idx_r;
  logic                               pend_r;
  logic                               hit_r;
  logic [CW-1:0]                      count_r, count_nxt;
  logic [pdr_pkg::REP_W-1:0]          dup_r, dup_nxt;
  logic                               out_valid_r, out_valid_nxt;

  logic [pdr_pkg::KEY_W-1:0]          key;
  logic                               full;
  logic                               store;
  logic [CW-1:0]                      cnt_new;
  logic [pdr_pkg::REP_W-1:0]          dup_new;

  assign key     = {key_x_r, key_y_r};
  assign full    = (count_r == FULL_CNT);
  assign store   = !hit_r && !full;
  assign cnt_new = count_r + CW'(store);
  assign dup_new = (hit_r && (dup_r != pdr_pkg::REP_MAX)) ? dup_r + 1'b1 : dup_r;

  // Once the read index reaches the stored count no further entry is read;
  // the compare of the last entry, if any, is in flight this cycle.
  assign stat.match    = pend_r && (rd_data_r == key);
  assign stat.scan_end = (idx_r == count_r);
  assign stat.out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    count_nxt = count_r;
    dup_nxt   = dup_r;
    if (cmd.commit) begin
      count_nxt = fin_r ? '0 : cnt_new;
      dup_nxt   = fin_r ? '0 : dup_new;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      dup_r       <= '0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      hit_r       <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      dup_r       <= dup_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= cmd.issue;
      if (cmd.start) begin
        idx_r <= '0;
        hit_r <= 1'b0;
      end else begin
        if (cmd.issue) begin
          idx_r <= idx_r + 1'b1;
        end
        if (stat.match) begin
          hit_r <= 1'b1;
        end
      end
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key_x_r <= px;
      key_y_r <= py;
      fin_r   <= final_point;
    end
    if (cmd.commit) begin
      out_ch.kept           <= !hit_r;
      out_ch.out_x          <= key_x_r;
      out_ch.out_y          <= key_y_r;
      out_ch.distinct_count <= pdr_pkg::DIST_W'(cnt_new);
      out_ch.repeat_count   <= dup_new;
      out_ch.table_overflow <= !hit_r && full;
      out_ch.figure_end     <= fin_r;
    end
  end

  // Table memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.commit && store) begin
      mem[count_r[AW-1:0]] <= key;
    end
    if (cmd.issue) begin
      rd_data_r <= mem[idx_r[AW-1:0]];
    end
  end

  assign out_ch.valid = out_valid_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("stored count above table size");

  a_read_written: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> (idx_r < count_r))
    else $error("read of an unwritten table entry");

  a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && !cmd.start && !fin_r && store |=> count_r == $past(count_r) + 1'b1)
    else $error("stored count did not advance on a new point");

endmodule

/* sv/pdr_ctrl.sv */
module pdr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pdr_pkg::pdr_stat_t stat,
  output pdr_pkg::pdr_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_RESULT = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt  = state_r;
    cmd.start  = 1'b0;
    cmd.issue  = 1'b0;
    cmd.commit = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat.match || stat.scan_end) begin
          state_nxt = ST_RESULT;
        end else begin
          cmd.issue = 1'b1;
        end
      end
      ST_RESULT: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> stat.out_free)
    else $error("result loaded while the output register is occupied");

  a_no_read_after_match: assert property (@(posedge clk) disable iff (!rst_n)
    stat.match |-> !cmd.issue)
    else $error("scan continued after a match");

  a_accept_then_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> !in_ready)
    else $error("second item accepted during a scan");

endmodule

/* sim/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned      COORD_W = pdr_pkg::COORD_W;
  localparam int unsigned      KEY_W   = pdr_pkg::KEY_W;
  localparam int unsigned      DIST_W  = pdr_pkg::DIST_W;
  localparam int unsigned      REP_W   = pdr_pkg::REP_W;
  localparam logic [REP_W-1:0] REP_MAX = pdr_pkg::REP_MAX;

  // The block is built with its default table size, so the overflow cases
  // below need figures of a little more than 256 distinct points.
  localparam int unsigned MAX_POINTS   = 256;
  localparam int unsigned RANDOM_ITEMS = 480;
  localparam int unsigned CALM_ITEMS   = 32;
  localparam int unsigned HOLD_CYCLES  = 600;
  localparam int unsigned MAX_REPORTS  = 10;
  // Well above the slowest legal run: every item scanning the whole table
  // with the longest gaps on both sides, plus the long receiver hold.
  localparam longint     LIMIT_NS     = 40_000_000;

  // One result item, in the order of the output fields.
  typedef struct packed {
    logic                      kept;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [DIST_W-1:0]         distinct;
    logic [REP_W-1:0]          repeats;
    logic                      overflow;
    logic                      fig_end;
  } verdict_t;

  // One row of the directed table. When typed is set, want is the result
  // written out by hand; otherwise the row is checked against the predictor.
  typedef struct packed {
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    logic               fin;
    logic               typed;
    verdict_t           want;
  } row_t;

  localparam int unsigned N_DIRECTED = 20;
  localparam row_t DIRECTED [N_DIRECTED] = '{
    // First figure: the first point after reset is always kept.
    '{16'h0000, 16'h0000, 1'b0, 1'b1, '{1, 16'h0000, 16'h0000, 1, 0, 0, 0}},
    '{16'h0000, 16'h0000, 1'b0, 1'b1, '{0, 16'h0000, 16'h0000, 1, 1, 0, 0}},
    '{16'h8000, 16'h7FFF, 1'b0, 1'b1, '{1, 16'h8000, 16'h7FFF, 2, 1, 0, 0}},
    // Same two values with x and y swapped is a different point.
    '{16'h7FFF, 16'h8000, 1'b0, 1'b1, '{1, 16'h7FFF, 16'h8000, 3, 1, 0, 0}},
    '{16'h8000, 16'h7FFF, 1'b0, 1'b1, '{0, 16'h8000, 16'h7FFF, 3, 2, 0, 0}},
    '{16'hFFFF, 16'hFFFF, 1'b0, 1'b0, '0},
    // Points that match a stored one in a single coordinate only, then two new ones.
    '{16'hFFFF, 16'h0000, 1'b0, 1'b0, '0},
    '{16'h0000, 16'hFFFF, 1'b0, 1'b0, '0},
    '{16'h0001, 16'h0000, 1'b0, 1'b0, '0},
    '{16'h5555, 16'hAAAA, 1'b0, 1'b0, '0},
    '{16'hAAAA, 16'h5555, 1'b0, 1'b0, '0},
    // A duplicate that also ends the figure.
    '{16'hFFFF, 16'hFFFF, 1'b1, 1'b0, '0},
    // A figure of one point: the table was cleared by the last item.
    '{16'h0000, 16'h0000, 1'b1, 1'b1, '{1, 16'h0000, 16'h0000, 1, 0, 0, 1}},
    '{16'h0000, 16'h0000, 1'b0, 1'b1, '{1, 16'h0000, 16'h0000, 1, 0, 0, 0}},
    '{16'h1234, 16'h8000, 1'b0, 1'b0, '0},
    '{16'h0000, 16'h0000, 1'b0, 1'b0, '0},
    '{16'h1234, 16'h8000, 1'b0, 1'b0, '0},
    '{16'h7FFF, 16'h7FFF, 1'b1, 1'b0, '0},
    '{16'h8000, 16'h8000, 1'b0, 1'b1, '{1, 16'h8000, 16'h8000, 1, 0, 0, 0}},
    '{16'h8000, 16'h8000, 1'b1, 1'b1, '{0, 16'h8000, 16'h8000, 1, 1, 0, 1}}
  };

  logic clk = 1'b0;
  logic rst_n;

  pdr_in_if  in_ch ();
  pdr_out_if out_ch ();

  point_duplicate_removal #(
    .MAX_POINTS(MAX_POINTS)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor state: the distinct points of the current figure and the
  // running repeat total, exactly as the block should hold them.
  logic [KEY_W-1:0] point_table [MAX_POINTS];
  int unsigned      stored_pts   = 0;
  logic [REP_W-1:0] repeat_total = '0;

  // Results still owed by the block, oldest first.
  verdict_t pending_verdicts [$];

  // Flags shared by the sender and the receiver.
  bit hold_request   = 1'b0;
  bit long_hold_done = 1'b0;
  bit calm           = 1'b0;

  int unsigned fails = 0;
  int unsigned n_results = 0, n_figures = 0, n_kept = 0, n_dropped = 0;
  int unsigned n_overflow = 0, max_repeat = 0;

  // Works out the result of one point and advances the predictor state.
  // Only entries below the stored count are compared, as in the block.
  function automatic verdict_t judge_point(logic [COORD_W-1:0] x,
                                           logic [COORD_W-1:0] y, logic fin);
    verdict_t         v;
    logic [KEY_W-1:0] key;
    bit               hit;
    key = {x, y};
    hit = 1'b0;
    for (int unsigned i = 0; i < stored_pts; i++)
      if (point_table[i] == key) hit = 1'b1;
    v = '0;
    if (hit) begin
      // The repeat total stops at its ceiling.
      if (repeat_total != REP_MAX) repeat_total++;
    end else begin
      v.kept = 1'b1;
      if (stored_pts < MAX_POINTS) begin
        point_table[stored_pts] = key;
        stored_pts++;
      end else begin
        // Table full: passed on but never stored, so never matched later.
        v.overflow = 1'b1;
      end
    end
    v.x        = x;
    v.y        = y;
    v.distinct = DIST_W'(stored_pts);
    v.repeats  = repeat_total;
    v.fig_end  = fin;
    // The final point reports the totals first; only then is the figure reset.
    if (fin) begin
      stored_pts   = 0;
      repeat_total = '0;
    end
    return v;
  endfunction

  // Offers one point and waits until the block takes it. An optional idle
  // burst comes before the point, with junk on the coordinate lines, so
  // that valid is lowered and raised in different time steps.
  task automatic offer_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                             input logic fin, input bit typed, input verdict_t want);
    verdict_t predicted;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      in_ch.px    <= COORD_W'($urandom);
      in_ch.py    <= COORD_W'($urandom);
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.px          <= x;
    in_ch.py          <= y;
    in_ch.final_point <= fin;
    do @(posedge clk); while (!in_ch.ready);
    // The predictor runs for every item, so its state stays in step even
    // where the expected result was written out by hand.
    predicted = judge_point(x, y, fin);
    pending_verdicts.push_back(typed ? want : predicted);
  endtask

  // Receiver: random stall bursts, long runs of ready, one long hold-off on
  // request, and no stalls at all once the run turns calm.
  initial begin
    out_ch.ready = 1'b0;
    wait (rst_n);
    forever begin
      if (hold_request) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request   = 1'b0;
        long_hold_done = 1'b1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  // Result checker: every accepted result is compared with the oldest
  // expectation, field by field.
  verdict_t got_res, want_res;
  string    bad_fields;

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got_res = '{out_ch.kept, out_ch.out_x, out_ch.out_y, out_ch.distinct_count,
                  out_ch.repeat_count, out_ch.table_overflow, out_ch.figure_end};
      if (pending_verdicts.size() == 0) begin
        fails++;
        if (fails <= MAX_REPORTS)
          $display("[%0t] unexpected result: kept=%0b x=%0d y=%0d dist=%0d rep=%0d ovf=%0b end=%0b",
                   $realtime, got_res.kept, got_res.x, got_res.y, got_res.distinct,
                   got_res.repeats, got_res.overflow, got_res.fig_end);
      end else begin
        want_res   = pending_verdicts.pop_front();
        bad_fields = "";
        if (got_res.kept     !== want_res.kept)     bad_fields = {bad_fields, " kept"};
        if (got_res.x        !== want_res.x)        bad_fields = {bad_fields, " out_x"};
        if (got_res.y        !== want_res.y)        bad_fields = {bad_fields, " out_y"};
        if (got_res.distinct !== want_res.distinct) bad_fields = {bad_fields, " distinct_count"};
        if (got_res.repeats  !== want_res.repeats)  bad_fields = {bad_fields, " repeat_count"};
        if (got_res.overflow !== want_res.overflow) bad_fields = {bad_fields, " table_overflow"};
        if (got_res.fig_end  !== want_res.fig_end)  bad_fields = {bad_fields, " figure_end"};
        if (bad_fields != "") begin
          fails++;
          if (fails <= MAX_REPORTS) begin
            $display("[%0t] result %0d wrong in:%s", $realtime, n_results, bad_fields);
            $display("  expected kept=%0b x=%0d y=%0d dist=%0d rep=%0d ovf=%0b end=%0b",
                     want_res.kept, want_res.x, want_res.y, want_res.distinct,
                     want_res.repeats, want_res.overflow, want_res.fig_end);
            $display("  actual   kept=%0b x=%0d y=%0d dist=%0d rep=%0d ovf=%0b end=%0b",
                     got_res.kept, got_res.x, got_res.y, got_res.distinct,
                     got_res.repeats, got_res.overflow, got_res.fig_end);
          end
        end
        n_results++;
        n_figures   += want_res.fig_end;
        n_kept      += want_res.kept;
        n_dropped   += !want_res.kept;
        n_overflow  += want_res.overflow;
        if (want_res.repeats > max_repeat) max_repeat = want_res.repeats;
      end
    end
  end

  // Stimulus: directed table, a figure that overfills the table, random
  // figures, and finally a calm figure made mostly of repeats.
  initial begin
    logic [KEY_W-1:0] pool [$];
    logic [KEY_W-1:0] key;
    logic [COORD_W-1:0] corner [5];
    int unsigned random_sent, fig_len, pool_len, mode, long_figs;
    bit hold_asked;

    corner = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001};
    random_sent = 0;
    long_figs   = 0;
    hold_asked  = 1'b0;

    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.px          = '0;
    in_ch.py          = '0;
    in_ch.final_point = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[r])
      offer_point(DIRECTED[r].px, DIRECTED[r].py, DIRECTED[r].fin,
                  DIRECTED[r].typed, DIRECTED[r].want);

    // Overfill the table: 260 distinct points, then the last overflowed
    // point again (still new, still not stored), then a stored point as a
    // duplicate that ends the figure.
    for (int unsigned k = 0; k < 260; k++) begin
      pool.push_back({COORD_W'(k - 130), COORD_W'($urandom)});
      offer_point(pool[k][KEY_W-1:COORD_W], pool[k][COORD_W-1:0], 1'b0, 1'b0, '0);
    end
    offer_point(pool[259][KEY_W-1:COORD_W], pool[259][COORD_W-1:0], 1'b0, 1'b0, '0);
    offer_point(pool[5][KEY_W-1:COORD_W], pool[5][COORD_W-1:0], 1'b1, 1'b0, '0);

    // Random figures. Most draw from a small pool of points so that
    // duplicates are common; some are fully random, some use only extreme
    // coordinates, and at most one is a long figure that can overflow the table again.
    while (random_sent < RANDOM_ITEMS) begin
      mode = $urandom_range(0, 99);
      pool.delete();
      if (mode < 3 && long_figs == 0) begin
        long_figs++;
        pool_len = 270;
        fig_len  = 300;
      end else if (mode < 70) begin
        pool_len = $urandom_range(1, 10);
        fig_len  = $urandom_range(1, 40);
      end else if (mode < 88) begin
        pool_len = $urandom_range(1, 20);
        fig_len  = pool_len;
      end else begin
        pool_len = 0;
        fig_len  = $urandom_range(1, 15);
        for (int unsigned k = 0; k < 6; k++)
          pool.push_back({corner[$urandom_range(0, 4)], corner[$urandom_range(0, 4)]});
      end
      for (int unsigned k = 0; k < pool_len; k++) begin
        // Now and then a point one bit away from the previous one.
        if (k > 0 && $urandom_range(0, 3) == 0)
          pool.push_back(pool[k-1] ^ (KEY_W'(1) << $urandom_range(0, KEY_W - 1)));
        else
          pool.push_back(KEY_W'($urandom));
      end
      for (int unsigned i = 0; i < fig_len; i++) begin
        // Walk the pool in order at first so new points come early, with
        // random repeats mixed in.
        if (i < pool.size() && $urandom_range(0, 7) != 0)
          key = pool[i];
        else
          key = pool[$urandom_range(0, pool.size() - 1)];
        offer_point(key[KEY_W-1:COORD_W], key[COORD_W-1:0], i == fig_len - 1, 1'b0, '0);
        random_sent++;
        // Part way through, the receiver holds off for a long stretch while
        // points keep coming, so the block backs up and stalls its input.
        if (!hold_asked && random_sent >= 300) begin
          hold_asked   = 1'b1;
          hold_request = 1'b1;
        end
      end
    end

    // Last part, no idling on either side: one point followed by a run of
    // back-to-back duplicates, the last of which ends the figure.
    calm = 1'b1;
    key  = KEY_W'($urandom);
    for (int unsigned n = 0; n < CALM_ITEMS; n++)
      offer_point(key[KEY_W-1:COORD_W], key[COORD_W-1:0], n == CALM_ITEMS - 1, 1'b0, '0);
    in_ch.valid <= 1'b0;

    while (pending_verdicts.size() != 0) @(posedge clk);
    // Any stray result would show within one full table scan.
    repeat (MAX_POINTS + 16) @(posedge clk);
    if (pending_verdicts.size() != 0) begin
      fails++;
      $display("%0d expected results never arrived", pending_verdicts.size());
    end

    $display("Checked %0d results over %0d figures: %0d kept, %0d dropped, %0d overflowed.",
             n_results, n_figures, n_kept, n_dropped, n_overflow);
    $display("Long receiver hold %0s; largest repeat total %0d; %0d failures.",
             long_hold_done ? "done" : "missed", max_repeat, fails);
    if (fails == 0)
      $display("** point_duplicate_removal: PASSED **");
    else
      $display("** point_duplicate_removal: FAILED **");
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(LIMIT_NS);
    $display("Timeout with %0d results still expected.", pending_verdicts.size());
    $display("** point_duplicate_removal: FAILED **");
    $finish;
  end

endmodule

/* sim.f */
sv/pdr_pkg.sv
sv/pdr_if.sv
sv/pdr_datapath.sv
sv/pdr_ctrl.sv
sv/point_duplicate_removal.sv
sim/testbench.sv
